// ===== hdl/md5ds_pkg.sv =====
`timescale 1ns / 1ps

package md5ds_pkg;

    localparam int BLOCK_BITS  = 512;
    localparam int QUEUE_DEPTH = 2;

    // last byte position that padding fills before the length field
    localparam logic [5:0] PAD_LAST_POS = 6'd55;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } t_out_item;

    typedef struct packed {
        logic                  last;
        logic [BLOCK_BITS-1:0] data;
    } t_blk_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        FE_DATA,
        FE_PAD,
        FE_LEN
    } t_fe_state;

    typedef enum logic [1:0] {
        CO_IDLE,
        CO_RUN,
        CO_ADD
    } t_co_state;

    // message word index for a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = i4;
            2'd1:    g = i4 * 4'd5 + 4'd1;
            2'd2:    g = i4 * 4'd3 + 4'd5;
            2'd3:    g = i4 * 4'd7;
            default: g = i4;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

endpackage

// ===== hdl/md5ds_front.sv =====
`timescale 1ns / 1ps

module md5ds_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  md5ds_pkg::t_in_item    i_in_item,
    input  md5ds_pkg::t_queue_status i_status,
    output logic                   o_push,
    output md5ds_pkg::t_blk_entry  o_entry
);

    md5ds_pkg::t_fe_state r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_bitcnt, n_bitcnt;
    logic [63:0] r_len, n_len;
    logic        r_first, n_first;
    logic [md5ds_pkg::BLOCK_BITS-1:0] r_fill, n_fill;

    logic       acc;
    logic       wr_en;
    logic [7:0] wr_byte;
    logic [63:0] cnt_sum;

    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            md5ds_pkg::FE_DATA: begin
                if (acc && i_in_item.end_of_message) begin
                    n_state = md5ds_pkg::FE_PAD;
                end
            end
            md5ds_pkg::FE_PAD: begin
                if (!i_status.full && r_pos == md5ds_pkg::PAD_LAST_POS) begin
                    n_state = md5ds_pkg::FE_LEN;
                end
            end
            md5ds_pkg::FE_LEN: begin
                if (!i_status.full && r_pos == md5ds_pkg::BLOCK_LAST_POS) begin
                    n_state = md5ds_pkg::FE_DATA;
                end
            end
            default: n_state = md5ds_pkg::FE_DATA;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        wr_en      = 1'b0;
        wr_byte    = 8'h00;
        n_bitcnt   = r_bitcnt;
        n_len      = r_len;
        n_first    = r_first;
        cnt_sum    = r_bitcnt + (i_in_item.byte_present ? 64'd8 : 64'd0);
        case (r_state)
            md5ds_pkg::FE_DATA: begin
                o_in_ready = !i_status.full;
                wr_en      = acc && i_in_item.byte_present;
                wr_byte    = i_in_item.data_byte;
                if (acc) begin
                    if (i_in_item.end_of_message) begin
                        // latch the final length, restart the count for the next message
                        n_len    = cnt_sum;
                        n_bitcnt = 64'd0;
                        n_first  = 1'b1;
                    end else begin
                        n_bitcnt = cnt_sum;
                    end
                end
            end
            md5ds_pkg::FE_PAD: begin
                wr_en   = !i_status.full;
                wr_byte = r_first ? md5ds_pkg::PAD_MARK : 8'h00;
                if (wr_en) begin
                    n_first = 1'b0;
                end
            end
            md5ds_pkg::FE_LEN: begin
                wr_en   = !i_status.full;
                wr_byte = r_len[{r_pos[2:0], 3'b000} +: 8];
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase

        n_fill = r_fill;
        if (wr_en) begin
            n_fill[{r_pos, 3'b000} +: 8] = wr_byte;
        end
        n_pos        = wr_en ? r_pos + 6'd1 : r_pos;
        o_push       = wr_en && r_pos == md5ds_pkg::BLOCK_LAST_POS;
        o_entry.data = n_fill;
        o_entry.last = (r_state == md5ds_pkg::FE_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= md5ds_pkg::FE_DATA;
            r_pos    <= 6'd0;
            r_bitcnt <= 64'd0;
            r_first  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_bitcnt <= n_bitcnt;
            r_first  <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill <= n_fill;
        r_len  <= n_len;
    end

endmodule

// ===== hdl/md5ds_fifo.sv =====
`timescale 1ns / 1ps

module md5ds_fifo #(
    parameter int DEPTH = md5ds_pkg::QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  md5ds_pkg::t_blk_entry    i_entry,
    input  logic                     i_pop,
    output md5ds_pkg::t_blk_entry    o_head,
    output md5ds_pkg::t_queue_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    md5ds_pkg::t_blk_entry r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rp];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        n_cnt = r_cnt + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

// ===== hdl/md5ds_core.sv =====
`timescale 1ns / 1ps

module md5ds_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  md5ds_pkg::t_blk_entry    i_head,
    input  md5ds_pkg::t_queue_status i_status,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output md5ds_pkg::t_out_item     o_out_item
);

    md5ds_pkg::t_co_state r_state, n_state;
    logic [31:0] r_h [4];
    logic [31:0] n_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [5:0]  r_rnd, n_rnd;
    logic        r_last, n_last;
    logic [md5ds_pkg::BLOCK_BITS-1:0] r_blk, n_blk;
    logic        r_out_valid, n_out_valid;
    md5ds_pkg::t_out_item r_out, n_out;

    logic        out_free;
    logic [31:0] f, m, t, t2;
    logic [3:0]  g;
    logic [31:0] s0, s1, s2, s3;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // one round per cycle
    always_comb begin
        case (r_rnd[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            2'd3:    f = r_c ^ (r_b | ~r_d);
            default: f = 32'd0;
        endcase
        g  = md5ds_pkg::msg_index(r_rnd);
        m  = r_blk[{g, 5'b00000} +: 32];
        t  = r_a + f + m + md5ds_pkg::K_TABLE[r_rnd];
        t2 = r_b + md5ds_pkg::rotl32(t, md5ds_pkg::ROT_TABLE[{r_rnd[5:4], r_rnd[1:0]}]);
        s0 = r_h[0] + r_a;
        s1 = r_h[1] + r_b;
        s2 = r_h[2] + r_c;
        s3 = r_h[3] + r_d;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            md5ds_pkg::CO_IDLE: begin
                if (!i_status.empty) begin
                    n_state = md5ds_pkg::CO_RUN;
                end
            end
            md5ds_pkg::CO_RUN: begin
                if (r_rnd == md5ds_pkg::ROUND_LAST) begin
                    n_state = md5ds_pkg::CO_ADD;
                end
            end
            md5ds_pkg::CO_ADD: begin
                if (!r_last || out_free) begin
                    n_state = md5ds_pkg::CO_IDLE;
                end
            end
            default: n_state = md5ds_pkg::CO_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_h         = r_h;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_rnd       = r_rnd;
        n_last      = r_last;
        n_blk       = r_blk;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            md5ds_pkg::CO_IDLE: begin
                if (!i_status.empty) begin
                    o_pop  = 1'b1;
                    n_blk  = i_head.data;
                    n_last = i_head.last;
                    n_a    = r_h[0];
                    n_b    = r_h[1];
                    n_c    = r_h[2];
                    n_d    = r_h[3];
                    n_rnd  = 6'd0;
                end
            end
            md5ds_pkg::CO_RUN: begin
                n_a   = r_d;
                n_b   = t2;
                n_c   = r_b;
                n_d   = r_c;
                n_rnd = r_rnd + 6'd1;
            end
            md5ds_pkg::CO_ADD: begin
                if (!r_last) begin
                    n_h = '{s0, s1, s2, s3};
                end else if (out_free) begin
                    // emit the digest and restart the chain for the next message
                    n_out_valid       = 1'b1;
                    n_out.digest_low  = {s1, s0};
                    n_out.digest_high = {s3, s2};
                    n_h               = md5ds_pkg::IV;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= md5ds_pkg::CO_IDLE;
            r_out_valid <= 1'b0;
            r_h         <= md5ds_pkg::IV;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_h         <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_rnd  <= n_rnd;
        r_last <= n_last;
        r_blk  <= n_blk;
        r_out  <= n_out;
    end

endmodule

// ===== hdl/md5_digest_stream.sv =====
`timescale 1ns / 1ps
// MD5 digest over a byte stream.
// Input channel (i_in_valid / o_in_ready / i_in_item): each transfer may carry
// one message byte (byte_present) and may close the message (end_of_message).
// Output channel (o_out_valid / i_out_ready / o_out_item): one 128-bit digest
// per message, digest byte 0 in bit 7:0 of digest_low.
// Flow: the byte packer takes one byte per cycle while the queue is not full
// and no padding is under way; the round unit works each 64-byte block in
// order (load, 64 rounds, chain add), so long messages are paced by the single
// round unit. A two-block queue between packer and round unit absorbs the
// difference. After end_of_message the packer writes the pad and length
// bytes, then the last block passes through the round unit, behind any
// blocks still queued ahead of it.
// While padding, o_in_ready stays low; the next message starts when it rises.
// Reset (synchronous, active low) restores the initial chain values, clears
// the byte count, empties the queue and drops any pending digest.
// If the receiver stalls, the digest holds in the output register; the round
// unit then waits before finishing the next message, and the queue and
// packer back up behind it.

module md5_digest_stream #(
    parameter int QUEUE_DEPTH = md5ds_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  md5ds_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output md5ds_pkg::t_out_item o_out_item
);

    logic                     push;
    logic                     pop;
    md5ds_pkg::t_blk_entry    push_entry;
    md5ds_pkg::t_blk_entry    head;
    md5ds_pkg::t_queue_status status;

    md5ds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_status   (status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    md5ds_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    md5ds_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hdl/md5ds_checker.sv =====
`timescale 1ns / 1ps

module md5ds_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input md5ds_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input md5ds_pkg::t_out_item o_out_item
);

    logic in_xfer_end;

    assign in_xfer_end = i_in_valid && o_in_ready && i_in_item.end_of_message;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("digest valid after reset");

    a_pad_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer_end |=> !o_in_ready)
        else $error("input taken while padding");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled digest changed");

endmodule

bind md5_digest_stream md5ds_checker u_md5ds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1100;
    localparam int DRAIN_CYCLES = 200;
    localparam int LEN_SLOT = 56;
    localparam bit [7:0] PAD_BYTE = 8'h80;

    localparam bit [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int SHIFT_BY [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // well-known digests, byte 0 in the low bits
    localparam bit [63:0] EMPTY_LO = 64'h04b2008fd98c1dd4;
    localparam bit [63:0] EMPTY_HI = 64'h7e42f8ec980980e9;
    localparam bit [63:0] STR_A_LO = 64'ha8b6f1c0b975c10c;
    localparam bit [63:0] STR_A_HI = 64'h61267769e299c331;
    localparam bit [63:0] ABC_LO   = 64'hb04fd23c98500190;
    localparam bit [63:0] ABC_HI   = 64'h727fe1287d3f96d6;

    typedef struct {
        md5ds_pkg::t_in_item  item;
        bit                   known;
        md5ds_pkg::t_out_item digest;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    md5ds_pkg::t_in_item  i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    md5ds_pkg::t_out_item o_out_item;

    // predictor state
    bit [31:0] chain [4];
    bit [31:0] blk [16];
    bit [63:0] msg_bits;

    md5ds_pkg::t_out_item digest_fifo [$];
    t_dir_row             directed_rows [$];

    bit calm = 1'b0;
    int errors = 0;
    int cycle_count = 0;
    int messages_sent = 0;
    int bytes_sent = 0;
    int idle_items_sent = 0;
    int digests_checked = 0;

    md5_digest_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit [31:0] spin_left(input bit [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_chain();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        msg_bits = '0;
    endfunction

    function automatic void fold_block();
        bit [31:0] a, b, c, d, f, t;
        int g, ph, i;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (i = 0; i < 64; i++) begin
            ph = i / 16;
            case (ph)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = a + f + blk[g] + SINE_K[i];
            t = b + spin_left(t, SHIFT_BY[ph * 4 + i % 4]);
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    // place a byte at its block slot; compress on the last slot
    function automatic int stash_byte(input int pos, input bit [7:0] v);
        blk[pos / 4][(pos % 4) * 8 +: 8] = v;
        pos = (pos + 1) % 64;
        if (pos == 0) fold_block();
        return pos;
    endfunction

    function automatic bit digest_step(input md5ds_pkg::t_in_item it,
                                       output md5ds_pkg::t_out_item d);
        bit [63:0] len;
        int pos, k;
        d = '0;
        if (it.byte_present) begin
            void'(stash_byte(int'(msg_bits[8:3]), it.data_byte));
            msg_bits += 64'd8;
        end
        if (!it.end_of_message) return 1'b0;
        len = msg_bits;
        pos = stash_byte(int'(len[8:3]), PAD_BYTE);
        while (pos != LEN_SLOT) pos = stash_byte(pos, 8'h00);
        for (k = 0; k < 8; k++) pos = stash_byte(pos, len[8 * k +: 8]);
        d.digest_low  = {chain[1], chain[0]};
        d.digest_high = {chain[3], chain[2]};
        restart_chain();
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void add_row(input bit [7:0] b, input bit p, input bit e,
                                    input bit k, input bit [63:0] lo, input bit [63:0] hi);
        t_dir_row r;
        r.item.data_byte      = b;
        r.item.byte_present   = p;
        r.item.end_of_message = e;
        r.known               = k;
        r.digest.digest_low   = lo;
        r.digest.digest_high  = hi;
        directed_rows.push_back(r);
    endfunction

    // entered just after a falling edge, leaves just after one
    task automatic send_item(input md5ds_pkg::t_in_item it, input bit fixed,
                             input md5ds_pkg::t_out_item fixed_digest);
        md5ds_pkg::t_out_item guess;
        while (!calm && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.byte_present) bytes_sent++;
        else if (!it.end_of_message) idle_items_sent++;
        if (it.end_of_message) messages_sent++;
        if (digest_step(it, guess)) digest_fifo.push_back(fixed ? fixed_digest : guess);
        @(negedge i_clk);
    endtask

    task automatic wait_for_digests();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (digest_fifo.size() != 0);
    endtask

    always @(negedge i_clk) begin
        if (!calm && $urandom_range(0, 99) < 22) i_out_ready <= 1'b0;
        else i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin : watch_digest
        md5ds_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_fifo.size() == 0) begin
                flag_mismatch($sformatf("digest %h with no message pending", o_out_item));
            end else begin
                want = digest_fifo.pop_front();
                digests_checked++;
                if (o_out_item.digest_low !== want.digest_low)
                    flag_mismatch($sformatf("digest_low got %h want %h",
                                            o_out_item.digest_low, want.digest_low));
                if (o_out_item.digest_high !== want.digest_high)
                    flag_mismatch($sformatf("digest_high got %h want %h",
                                            o_out_item.digest_high, want.digest_high));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digests pending",
                     cycle_count, digest_fifo.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        md5ds_pkg::t_in_item it;
        int items_sent, len, j, sel, msg_no;
        bit close_on_last;

        restart_chain();
        blk = '{default: '0};

        // empty message, ignored items, one-byte and three-byte strings
        add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_LO, EMPTY_HI);
        add_row(8'hff, 1'b0, 1'b0, 1'b0, '0, '0);
        add_row(8'h61, 1'b1, 1'b1, 1'b1, STR_A_LO, STR_A_HI);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0, '0);
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'h63, 1'b1, 1'b1, 1'b1, ABC_LO, ABC_HI);
        // byte extremes, closed by an end with no byte
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'hff, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'h80, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'h7f, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'haa, 1'b0, 1'b1, 1'b0, '0, '0);
        // data on an end without a byte must be dropped
        add_row(8'hff, 1'b0, 1'b1, 1'b1, EMPTY_LO, EMPTY_HI);
        add_row(8'hff, 1'b1, 1'b1, 1'b0, '0, '0);
        add_row(8'h55, 1'b0, 1'b0, 1'b0, '0, '0);
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'haa, 1'b0, 1'b0, 1'b0, '0, '0);
        add_row(8'h33, 1'b0, 1'b1, 1'b1, STR_A_LO, STR_A_HI);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].digest);

        items_sent = 0;
        msg_no = 0;
        while (items_sent < ITEM_TARGET) begin
            msg_no++;
            calm = (msg_no >= 8 && msg_no < 14);
            sel = $urandom_range(0, 99);
            if (sel < 35) len = $urandom_range(0, 8);
            else if (sel < 70) len = $urandom_range(9, 60);
            else if (sel < 90) len = $urandom_range(54, 66);
            else len = $urandom_range(118, 130);
            close_on_last = (len > 0) && ($urandom_range(0, 1) == 1);
            for (j = 0; j < len; j++) begin
                if ($urandom_range(0, 99) < 8) begin
                    it.data_byte      = 8'($urandom_range(0, 255));
                    it.byte_present   = 1'b0;
                    it.end_of_message = 1'b0;
                    send_item(it, 1'b0, '0);
                end
                it.data_byte      = 8'($urandom_range(0, 255));
                it.byte_present   = 1'b1;
                it.end_of_message = close_on_last && (j == len - 1);
                send_item(it, 1'b0, '0);
                items_sent++;
            end
            if (!close_on_last) begin
                it.data_byte      = 8'($urandom_range(0, 255));
                it.byte_present   = 1'b0;
                it.end_of_message = 1'b1;
                send_item(it, 1'b0, '0);
                items_sent++;
            end
            // hold off until every digest is out
            if (msg_no == 4) wait_for_digests();
        end
        calm = 1'b0;

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages (empty, short, block-boundary and multi-block lengths)",
                 messages_sent);
        $display("sent %0d bytes and %0d empty transfers; %0d digests compared",
                 bytes_sent, idle_items_sent, digests_checked);
        if (errors == 0 && digest_fifo.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/md5ds_pkg.sv
hdl/md5ds_front.sv
hdl/md5ds_fifo.sv
hdl/md5ds_core.sv
hdl/md5_digest_stream.sv
hdl/md5ds_checker.sv
tb/tb_top.sv
